// ----- src/rmth_pkg.sv -----
`default_nettype none

package rmth_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int VALUE_BITS = 16;
  localparam int SIZE_BITS  = $clog2(HEAP_DEPTH + 1);
  localparam int TOTAL_BITS = SIZE_BITS + 1;
  localparam int COUNT_BITS = 11;

  localparam logic [TOTAL_BITS-1:0] CAPACITY = TOTAL_BITS'(2 * HEAP_DEPTH - 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [SIZE_BITS-1:0]  size_t;

  // one operation broadcast to every cell of a chain
  typedef struct packed {
    logic   push;
    logic   pop;
    value_t value;
  } rmth_op_t;

  // handed from a cell to its right neighbor
  typedef struct packed {
    logic   above;
    value_t value;
  } rmth_link_t;

endpackage

`default_nettype wire

// ----- src/rmth_cell.sv -----
`default_nettype none

module rmth_cell (
  input  wire                   clk,
  input  wire                   is_max,
  input  wire                   occupied,
  input  rmth_pkg::rmth_op_t    op,
  input  rmth_pkg::rmth_link_t  left,
  input  rmth_pkg::value_t      right_value,
  output rmth_pkg::rmth_link_t  link_out
);
  import rmth_pkg::*;

  value_t value_r;
  value_t value_nxt;
  logic   above;

  // stays ahead of the new value: keeps its place on a push
  assign above = occupied && (is_max ? (value_r >= op.value) : (value_r <= op.value));

  always_comb begin
    value_nxt = value_r;
    if (op.push) begin
      if (!above) begin
        value_nxt = left.above ? op.value : left.value;
      end
    end else if (op.pop) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign link_out.above = above;
  assign link_out.value = value_r;

endmodule

`default_nettype wire

// ----- src/rmth_chain.sv -----
`default_nettype none

module rmth_chain (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 is_max,
  input  rmth_pkg::rmth_op_t  op,
  output rmth_pkg::value_t    top_value,
  output rmth_pkg::size_t     size
);
  import rmth_pkg::*;

  rmth_link_t links [HEAP_DEPTH+1];
  size_t      size_r;
  size_t      size_nxt;

  // head cell always sees the new value as its own slot
  assign links[0].above = 1'b1;
  assign links[0].value = '0;

  for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
    value_t right_value;
    if (i == HEAP_DEPTH - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_mid
      assign right_value = links[i+2].value;
    end

    rmth_cell u_cell (
      .clk         (clk),
      .is_max      (is_max),
      .occupied    (size_r > SIZE_BITS'(i)),
      .op          (op),
      .left        (links[i]),
      .right_value (right_value),
      .link_out    (links[i+1])
    );
  end

  always_comb begin
    size_nxt = size_r;
    if (op.push) begin
      size_nxt = size_r + SIZE_BITS'(1);
    end else if (op.pop) begin
      size_nxt = size_r - SIZE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
    end else begin
      size_r <= size_nxt;
    end
  end

  assign top_value = links[1].value;
  assign size      = size_r;

endmodule

`default_nettype wire

// ----- src/running_median_two_heaps_core.sv -----
`default_nettype none

// Channel  Direction  Ports                                        Accepted when
// in       input      in_sample_value                              in_valid  && in_ready
// out      output     out_median_value, out_item_count, out_refused out_valid && out_ready
//
// Steps per item: accept, push, rebalance, result load; a refused item skips
// push and rebalance. Each heap is a row of cells kept in heap order, head
// cell first, so a push or a pop updates every cell of the row together.
// Reset clears both heap sizes and the control state; cell contents stay as they are.
// A new item is taken while a result still waits at the output register; a
// stalled output holds the block in its result-load step.
module running_median_two_heaps_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [rmth_pkg::VALUE_BITS-1:0] in_sample_value,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [rmth_pkg::VALUE_BITS-1:0] out_median_value,
  output logic [rmth_pkg::COUNT_BITS-1:0] out_item_count,
  output logic                         out_refused
);
  import rmth_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_BAL,
    S_DONE
  } state_t;

  state_t    state_r;
  value_t    sample_r;
  logic      refused_r;
  logic      out_valid_r;
  value_t    median_r;
  logic [COUNT_BITS-1:0] count_r;
  logic      out_refused_r;

  rmth_op_t  lo_op;
  rmth_op_t  hi_op;
  value_t    lo_top;
  value_t    hi_top;
  size_t     lo_size;
  size_t     hi_size;

  logic [TOTAL_BITS-1:0] total;
  logic [TOTAL_BITS-1:0] lo_plus1;
  logic [TOTAL_BITS-1:0] hi_plus1;
  logic      to_lower;
  logic      hi_heavy;
  logic      lo_heavy;
  value_t    median;
  logic      out_load;

  // lower half: max order; upper half: min order
  rmth_chain u_lower (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_max    (1'b1),
    .op        (lo_op),
    .top_value (lo_top),
    .size      (lo_size)
  );

  rmth_chain u_upper (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_max    (1'b0),
    .op        (hi_op),
    .top_value (hi_top),
    .size      (hi_size)
  );

  assign total    = TOTAL_BITS'(lo_size) + TOTAL_BITS'(hi_size);
  assign lo_plus1 = TOTAL_BITS'(lo_size) + TOTAL_BITS'(1);
  assign hi_plus1 = TOTAL_BITS'(hi_size) + TOTAL_BITS'(1);
  assign hi_heavy = TOTAL_BITS'(hi_size) > lo_plus1;
  assign lo_heavy = TOTAL_BITS'(lo_size) > hi_plus1;

  // result register loads when the last step is reached and the slot is free
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // routing: at most lower top goes low, at least upper top goes high,
  // otherwise the smaller heap, ties low; an empty heap never matches
  always_comb begin
    if (lo_size != '0 && sample_r <= lo_top) begin
      to_lower = 1'b1;
    end else if (hi_size != '0 && sample_r >= hi_top) begin
      to_lower = 1'b0;
    end else begin
      to_lower = !(hi_size < lo_size);
    end
  end

  // chain operations for the current step
  always_comb begin
    lo_op = '{push: 1'b0, pop: 1'b0, value: sample_r};
    hi_op = '{push: 1'b0, pop: 1'b0, value: sample_r};
    case (state_r)
      S_PUSH: begin
        lo_op.push = to_lower;
        hi_op.push = !to_lower;
      end
      S_BAL: begin
        // move one top across when sizes differ by two
        if (hi_heavy) begin
          hi_op.pop   = 1'b1;
          lo_op.push  = 1'b1;
          lo_op.value = hi_top;
        end else if (lo_heavy) begin
          lo_op.pop   = 1'b1;
          hi_op.push  = 1'b1;
          hi_op.value = lo_top;
        end
      end
      default: begin
      end
    endcase
  end

  // median: top of the larger heap, lower top on equal sizes, zero when both are empty
  always_comb begin
    if (hi_size > lo_size) begin
      median = hi_top;
    end else if (lo_size == '0) begin
      median = '0;
    end else begin
      median = lo_top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            sample_r  <= in_sample_value;
            // full store: drop the item, report unchanged median and count
            refused_r <= (total >= CAPACITY);
            state_r   <= (total >= CAPACITY) ? S_DONE : S_PUSH;
          end
        end
        S_PUSH: begin
          state_r <= S_BAL;
        end
        S_BAL: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            median_r      <= median;
            count_r       <= total[COUNT_BITS-1:0];
            out_refused_r <= refused_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_median_value = median_r;
  assign out_item_count   = count_r;
  assign out_refused      = out_refused_r;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`default_nettype none

// Bench for the two-heap running median core. A queue of samples feeds a
// valid/ready driver; a monitor predicts each median as its sample is taken
// and checks every result item in order against that prediction.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rmth_pkg::value_t;

  localparam int DEPTH        = rmth_pkg::HEAP_DEPTH;
  localparam int CNT_W        = rmth_pkg::COUNT_BITS;
  localparam int STORE_LIMIT  = 2 * DEPTH - 1;   // values held at most, both heaps
  localparam int N_ITEMS      = 1350;            // samples sent in the run
  localparam int IDLE_PCT     = 18;
  localparam int QUIET_FROM   = 3000;            // window with no idling on either side
  localparam int QUIET_TO     = 4500;
  localparam int HOLD_AT      = 1500;            // receiver hold-off start, in cycles
  localparam int HOLD_LEN     = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef enum bit {LOWER_SIDE, UPPER_SIDE} heap_side_t;

  typedef struct packed {
    value_t           median;
    logic [CNT_W-1:0] count;
    logic             refused;
  } median_result_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  // DUT inputs, all known from time zero
  logic   in_valid        = 1'b0;
  value_t in_sample_value = '0;
  logic   out_ready       = 1'b0;

  // DUT outputs
  logic             in_ready;
  logic             out_valid;
  value_t           out_median_value;
  logic [CNT_W-1:0] out_item_count;
  logic             out_refused;

  running_median_two_heaps_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_median_value (out_median_value),
    .out_item_count   (out_item_count),
    .out_refused      (out_refused)
  );

  // bench state
  value_t         sample_q [$];   // samples not yet taken by the core
  median_result_t median_q [$];   // predicted results, oldest first
  int             cyc             = 0;
  int unsigned    n_accepted      = 0;
  int unsigned    n_results       = 0;
  int unsigned    n_refused       = 0;
  int unsigned    n_mismatch      = 0;
  int unsigned    in_stall_cycles = 0;
  int unsigned    peak_count      = 0;

  // predictor copy of the two heaps: lower is a max-heap, upper a min-heap
  value_t heap_mem [2][DEPTH];
  int     heap_len [2] = '{0, 0};

  function automatic void add_sample(value_t v);
    sample_q = {sample_q, v};
  endfunction

  function automatic bit outranks(heap_side_t side, value_t a, value_t b);
    return (side == LOWER_SIDE) ? (a > b) : (a < b);
  endfunction

  task automatic heap_insert(heap_side_t side, value_t v);
    int     i;
    int     p;
    value_t t;
    if (heap_len[side] < DEPTH) begin
      i = heap_len[side];
      heap_mem[side][i] = v;
      heap_len[side]++;
      // sift up until the parent keeps order
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!outranks(side, heap_mem[side][i], heap_mem[side][p])) break;
        t = heap_mem[side][i];
        heap_mem[side][i] = heap_mem[side][p];
        heap_mem[side][p] = t;
        i = p;
      end
    end
  endtask

  task automatic heap_extract(heap_side_t side, output value_t top);
    int     n;
    int     i;
    int     l;
    int     r;
    int     best;
    value_t t;
    top = '0;
    if (heap_len[side] != 0) begin
      top = heap_mem[side][0];
      n = heap_len[side] - 1;
      heap_mem[side][0] = heap_mem[side][n];
      heap_len[side] = n;
      i = 0;
      // sift down; a lone left child is still compared
      forever begin
        l = 2 * i + 1;
        r = l + 1;
        if (l >= n) break;
        best = l;
        if (r < n && outranks(side, heap_mem[side][r], heap_mem[side][l])) best = r;
        if (!outranks(side, heap_mem[side][best], heap_mem[side][i])) break;
        t = heap_mem[side][i];
        heap_mem[side][i] = heap_mem[side][best];
        heap_mem[side][best] = t;
        i = best;
      end
    end
  endtask

  function automatic value_t median_now();
    if (heap_len[UPPER_SIDE] > heap_len[LOWER_SIDE]) return heap_mem[UPPER_SIDE][0];
    if (heap_len[LOWER_SIDE] == 0) return '0;
    return heap_mem[LOWER_SIDE][0];
  endfunction

  // advance the predictor by one sample and queue the result it gives
  task automatic predict_median(value_t v);
    median_result_t r;
    int             total;
    bit             to_lower;
    value_t         moved;
    total = heap_len[LOWER_SIDE] + heap_len[UPPER_SIDE];
    if (total >= STORE_LIMIT) begin
      // full store: sample dropped, median and count unchanged
      r.median  = median_now();
      r.count   = CNT_W'(total);
      r.refused = 1'b1;
    end else begin
      // an empty heap never matches; ties between equal sizes go low
      if (heap_len[LOWER_SIDE] != 0 && v <= heap_mem[LOWER_SIDE][0])
        to_lower = 1'b1;
      else if (heap_len[UPPER_SIDE] != 0 && v >= heap_mem[UPPER_SIDE][0])
        to_lower = 1'b0;
      else
        to_lower = !(heap_len[UPPER_SIDE] < heap_len[LOWER_SIDE]);
      heap_insert(to_lower ? LOWER_SIDE : UPPER_SIDE, v);
      // rebalance when the sizes are two apart
      if (heap_len[UPPER_SIDE] > heap_len[LOWER_SIDE] + 1) begin
        heap_extract(UPPER_SIDE, moved);
        heap_insert(LOWER_SIDE, moved);
      end else if (heap_len[LOWER_SIDE] > heap_len[UPPER_SIDE] + 1) begin
        heap_extract(LOWER_SIDE, moved);
        heap_insert(UPPER_SIDE, moved);
      end
      r.median  = median_now();
      r.count   = CNT_W'(heap_len[LOWER_SIDE] + heap_len[UPPER_SIDE]);
      r.refused = 1'b0;
    end
    median_q = {median_q, r};
  endtask

  // one line per mismatch, counted
  task automatic flag_mismatch(string what, longint got, longint want);
    n_mismatch++;
    $display("%0t ns: mismatch on %s: got %0d, expected %0d (result %0d)",
             $realtime, what, got, want, n_results);
  endtask

  // reset: held low at the start, released on a falling edge, never again
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  wire quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  // driver: offers the head of sample_q, holds it until taken
  always @(negedge clk) begin : drive_in
    bit          idle_now;
    bit          holding;
    int unsigned offered_at;
    idle_now = !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    holding  = in_valid && (n_accepted == offered_at);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!holding) begin
      if (sample_q.size() != 0 && !idle_now) begin
        in_valid        <= 1'b1;
        in_sample_value <= sample_q[0];
        offered_at      = n_accepted;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off that backs the core up
  always @(negedge clk) begin : drive_ready
    int  hold_left;
    bit  hold_done;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (cyc >= HOLD_AT && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // monitor: predict on each taken sample, check each delivered result item
  always @(posedge clk) begin : watch
    median_result_t want;
    if (rst_n) begin
      cyc++;
      if (in_valid && in_ready) begin
        predict_median(in_sample_value);
        void'(sample_q.pop_front());
        n_accepted++;
      end else if (in_valid) begin
        in_stall_cycles++;
      end
      if (out_valid && out_ready) begin
        if (median_q.size() == 0) begin
          flag_mismatch("unexpected item", out_median_value, -1);
        end else begin
          want = median_q.pop_front();
          if (out_median_value !== want.median)
            flag_mismatch("median_value", out_median_value, want.median);
          if (out_item_count !== want.count)
            flag_mismatch("item_count", out_item_count, want.count);
          if (out_refused !== want.refused)
            flag_mismatch("refused", out_refused, want.refused);
          if (want.refused) n_refused++;
          if (want.count > peak_count) peak_count = want.count;
        end
        n_results++;
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    // extremes, ties at both tops, values between the tops
    value_t directed [20] = '{
      16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 16'h8000,
      16'h7FFF, 16'h8001, 16'h0001, 16'hFFFE, 16'h1234, 16'h1234, 16'h4000,
      16'hC000, 16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF, 16'h8000};
    int     run_left;
    bit     run_up;
    value_t run_val;
    foreach (directed[k]) add_sample(directed[k]);

    // random part with monotonic runs, clusters and extremes
    run_left = 0;
    while (sample_q.size() < N_ITEMS) begin
      if (run_left == 0 && $urandom_range(0, 19) == 0) begin
        // monotonic runs push one heap ahead and force rebalancing
        run_left = $urandom_range(8, 40);
        run_val  = value_t'($urandom);
        run_up   = $urandom_range(0, 1);
      end
      if (run_left != 0) begin
        run_val = run_up ? run_val + value_t'($urandom_range(0, 300))
                         : run_val - value_t'($urandom_range(0, 300));
        run_left--;
        add_sample(run_val);
      end else begin
        case ($urandom_range(0, 9))
          0:       add_sample('0);
          1:       add_sample('1);
          2, 3:    add_sample(value_t'(16'h7FFC + $urandom_range(0, 7)));
          4:       add_sample(value_t'($urandom_range(0, 3)));
          default: add_sample(value_t'($urandom));
        endcase
      end
    end

    wait (rst_n);
    while (sample_q.size() != 0 || median_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (median_q.size() != 0)
      flag_mismatch("results never delivered", 0, median_q.size());

    $display("Run: %0d samples taken, %0d results checked, %0d refused at full store",
             n_accepted, n_results, n_refused);
    $display("Peak count %0d, %0d input stall cycles, %0d mismatches",
             peak_count, in_stall_cycles, n_mismatch);
    if (n_mismatch == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Timeout: %0d samples still pending, %0d results outstanding",
             sample_q.size(), median_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
